FILE: rtl/kmer_pkg.sv
// ----------------------------------------------------------------------------
// kmer_pkg: shared types and constants for the k-mer count table
// Status codes, modes, sequencer states and the 64-bit hash mix.
// ----------------------------------------------------------------------------
package kmer_pkg;

    localparam int unsigned DEPTH_DEFAULT = 4096;
    localparam int unsigned FILL_W = 13;
    localparam logic [12:0] MAX_FILL_RESET = 13'd3072;
    localparam logic [7:0]  COUNT_SAT = 8'd15;
    localparam logic [2:0]  BASE_UNKNOWN = 3'd4;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_SPARE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DELETED   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_MIX,
        S_FOLD,
        S_QUOT,
        S_REM,
        S_FIX,
        S_READ,
        S_CHECK,
        S_OUT
    } state_t;

    // One step of the mix; step selects which of the eight operations.
    function automatic logic [63:0] mix_step(input logic [63:0] k, input logic [2:0] step);
        logic [63:0] r;
        case (step)
            3'd0: r = k + ~(k << 32);
            3'd1: r = k ^ (k >> 22);
            3'd2: r = k + ~(k << 13);
            3'd3: r = k ^ (k >> 8);
            3'd4: r = k + (k << 3);
            3'd5: r = k ^ (k >> 15);
            3'd6: r = k + ~(k << 27);
            default: r = k ^ (k >> 31);
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/kmer_count_hash_table_top.sv
// ----------------------------------------------------------------------------
// kmer_count_hash_table_top: k-mer counting hash table
// Linear-probing table of 128-bit keys with counts that stop growing once
// they reach COUNT_SAT, and neighbour-base branch flags.
// ----------------------------------------------------------------------------
// Input channel: valid/stall carrying mode, key_upper, key_low, add_count,
// left_base and right_base. Output channel: valid/stall carrying status,
// slot_index, count, left_branch and right_branch, one result per request.
// Configuration: cfg_valid/cfg_ready write of max_fill, taken only while
// the block is idle and no request is offered.
// One request at a time. The hash runs one mix operation per cycle, with
// both halves side by side. The slot reduction takes the low hash bits at a
// power of two depth, else it goes through one shared 32x32 multiplier
// (fold the upper word, reciprocal quotient, remainder, final subtract).
// Each probed slot is read (S_READ) and then checked (S_CHECK) through
// the single read port. After reset a clearing pass over every slot
// empties the slot flag memory; in_stall stays high until it ends. While
// the receiver stalls, the result is held and no new request is taken.
// ----------------------------------------------------------------------------
module kmer_count_hash_table_top
    import kmer_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [63:0] key_upper,
    input  logic [63:0] key_low,
    input  logic [3:0]  add_count,
    input  logic [2:0]  left_base,
    input  logic [2:0]  right_base,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [11:0] slot_index,
    output logic [7:0]  count,
    output logic        left_branch,
    output logic        right_branch,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] max_fill
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned PW = AW + 1;
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
    localparam logic [PW-1:0] DEPTH_P = PW'(TABLE_DEPTH);
    localparam bit POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [31:0] FOLD_C = 32'((64'd1 << 32) % 64'(TABLE_DEPTH));
    localparam int unsigned RSH = 31 + AW;
    localparam logic [31:0] RECIP = 32'((64'd1 << RSH) / 64'(TABLE_DEPTH));
    localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

    typedef struct packed {
        logic [127:0] key;
        logic [7:0]   cnt;
        logic [2:0]   lb;
        logic [2:0]   rb;
        logic [1:0]   fl;
    } entry_t;

    entry_t      mem [TABLE_DEPTH];
    logic [1:0]  flag_mem [TABLE_DEPTH];

    state_t      state_reg, state_next;
    logic [1:0]  mode_reg;
    logic [127:0] key_reg;
    logic [3:0]  add_reg;
    logic [2:0]  lb_reg, rb_reg;
    logic [63:0] h_reg, l_reg, h_next, l_next;
    logic [2:0]  step_reg, step_next;
    logic [AW-1:0] home_reg, home_next, p_reg, p_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [PW-1:0] n_reg, n_next;
    logic [12:0] total_reg, fill_reg;
    entry_t      rd_reg;
    logic        fil_reg, del_reg;
    logic        wr_en;
    entry_t      wr_data;
    logic        flag_we;
    logic [1:0]  flag_wd;
    logic [2:0]  st_reg, st_next;
    logic [AW-1:0] oslot_reg, oslot_next;
    logic [7:0]  ocnt_reg, ocnt_next;
    logic [1:0]  ofl_reg, ofl_next;
    logic        inc_total;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] fix_w;
    entry_t      upd;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign out_valid = (state_reg == S_OUT);
    assign status    = st_reg;
    assign slot_index = 12'(oslot_reg);
    assign count     = ocnt_reg;
    assign left_branch  = ofl_reg[0];
    assign right_branch = ofl_reg[1];

    always_comb
    begin
        case (state_reg)
            S_QUOT:
            begin
                mul_a = h_reg[31:0];
                mul_b = RECIP;
            end
            S_REM:
            begin
                mul_a = l_reg[31:0];
                mul_b = DEPTH_W;
            end
            default:
            begin
                mul_a = h_reg[63:32];
                mul_b = FOLD_C;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);
    assign fix_w = (h_reg >= 64'(DEPTH_W)) ? h_reg - 64'(DEPTH_W) : h_reg;

    always_comb
    begin
        upd = rd_reg;
        if (rd_reg.cnt < COUNT_SAT)
        begin
            upd.cnt = rd_reg.cnt + 8'(add_reg);
        end
        if (lb_reg < BASE_UNKNOWN)
        begin
            if (rd_reg.lb == BASE_UNKNOWN)
                upd.lb = lb_reg;
            else if (rd_reg.lb != lb_reg)
                upd.fl[0] = 1'b1;
        end
        if (rb_reg < BASE_UNKNOWN)
        begin
            if (rd_reg.rb == BASE_UNKNOWN)
                upd.rb = rb_reg;
            else if (rd_reg.rb != rb_reg)
                upd.fl[1] = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        h_next = h_reg;
        l_next = l_reg;
        step_next = step_reg;
        home_next = home_reg;
        p_next = p_reg;
        n_next = n_reg;
        clr_next = clr_reg;
        st_next = st_reg;
        oslot_next = oslot_reg;
        ocnt_next = ocnt_reg;
        ofl_next = ofl_reg;
        wr_en = 1'b0;
        wr_data = upd;
        flag_we = 1'b0;
        flag_wd = 2'b00;
        inc_total = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                h_next = key_upper;
                l_next = key_low;
                step_next = '0;
                if (in_valid)
                    state_next = S_MIX;
            end
            S_MIX:
            begin
                h_next = mix_step(h_reg, step_reg);
                l_next = mix_step(l_reg, step_reg);
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    h_next = mix_step(h_reg, 3'd7) ^ mix_step(l_reg, 3'd7);
                    step_next = '0;
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                if (POW2)
                begin
                    home_next = AW'(h_reg);
                    p_next = AW'(h_reg);
                    n_next = '0;
                    state_next = S_READ;
                end
                else if (h_reg[63:32] != 32'd0)
                    h_next = mul_p + 64'(h_reg[31:0]);
                else
                    state_next = S_QUOT;
            end
            S_QUOT:
            begin
                l_next = mul_p >> RSH;
                state_next = S_REM;
            end
            S_REM:
            begin
                h_next = h_reg - mul_p;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                home_next = AW'(fix_w);
                p_next = AW'(fix_w);
                n_next = '0;
                state_next = S_READ;
            end
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
            begin
                state_next = S_OUT;
                oslot_next = home_reg;
                ocnt_next = '0;
                ofl_next = '0;
                if (!fil_reg)
                begin
                    if (mode_reg == MODE_INSERT)
                    begin
                        if (total_reg >= fill_reg)
                            st_next = ST_FULL;
                        else
                        begin
                            st_next = ST_INSERTED;
                            oslot_next = p_reg;
                            ocnt_next = 8'(add_reg);
                            wr_en = 1'b1;
                            wr_data = '{key: key_reg, cnt: 8'(add_reg), lb: lb_reg,
                                        rb: rb_reg, fl: 2'b00};
                            flag_we = 1'b1;
                            flag_wd = 2'b01;
                            inc_total = 1'b1;
                        end
                    end
                    else
                        st_next = ST_NOT_FOUND;
                end
                else if (rd_reg.key == key_reg)
                begin
                    if (mode_reg == MODE_INSERT)
                    begin
                        st_next = ST_UPDATED;
                        oslot_next = p_reg;
                        ocnt_next = upd.cnt;
                        ofl_next = upd.fl;
                        wr_en = 1'b1;
                    end
                    else if (del_reg)
                        st_next = ST_NOT_FOUND;
                    else
                    begin
                        oslot_next = p_reg;
                        ocnt_next = rd_reg.cnt;
                        ofl_next = rd_reg.fl;
                        if (mode_reg == MODE_DELETE)
                        begin
                            st_next = ST_DELETED;
                            flag_we = 1'b1;
                            flag_wd = 2'b11;
                        end
                        else
                            st_next = ST_FOUND;
                    end
                end
                else if (n_reg == DEPTH_P - PW'(1))
                    st_next = (mode_reg == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
                else
                begin
                    n_next = n_reg + PW'(1);
                    p_next = (p_reg == LAST) ? '0 : p_reg + AW'(1);
                    state_next = S_READ;
                end
            end
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            total_reg <= '0;
            fill_reg <= MAX_FILL_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            if (cfg_valid && cfg_ready)
                fill_reg <= max_fill;
            if (inc_total)
                total_reg <= total_reg + 13'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            mode_reg <= mode;
            key_reg <= {key_upper, key_low};
            add_reg <= add_count;
            lb_reg <= left_base;
            rb_reg <= right_base;
        end
        h_reg <= h_next;
        l_reg <= l_next;
        step_reg <= step_next;
        home_reg <= home_next;
        p_reg <= p_next;
        n_reg <= n_next;
        st_reg <= st_next;
        oslot_reg <= oslot_next;
        ocnt_reg <= ocnt_next;
        ofl_reg <= ofl_next;
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[p_reg];
        if (wr_en)
            mem[p_reg] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        {del_reg, fil_reg} <= flag_mem[p_reg];
        if (state_reg == S_CLEAR)
            flag_mem[clr_reg] <= 2'b00;
        else if (flag_we)
            flag_mem[p_reg] <= flag_wd;
    end

endmodule
